### design/erxaf_pkg.sv
// Shared types, constants and CRC helper for the receive address filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package erxaf_pkg;

  localparam int ADDR_W     = 48;
  localparam int CRC_W      = 32;
  localparam int HASH_W     = 6;
  localparam int FILTER_W   = 64;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BYTE_W     = 8;
  localparam int CRC_STAGES = ADDR_W / BYTE_W;

  localparam logic [CRC_W-1:0]  CRC_POLY  = 32'h04c1_1db7;
  localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hffff_ffff;
  localparam logic [ADDR_W-1:0] ADDR_BCAST = 48'hffff_ffff_ffff;

  localparam logic [MODE_W-1:0] MODE_OFF       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MULTICAST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PROMISC   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MCAST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOPPED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOPBACK = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0]   station_address;
    logic [FILTER_W-1:0] multicast_filter;
    logic [MODE_W-1:0]   filter_mode;
    logic                receiver_stopped;
    logic                loopback_on;
  } cfg_t;

  // Word travelling down the CRC pipeline.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] rest;
    logic              looped;
    logic [CRC_W-1:0]  crc;
  } stage_t;

  // Advance the CRC over one byte, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = c[CRC_W-1] ^ data[k];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/erxaf_cfg.sv
// Configuration register file of the receive address filter.
// Depends on erxaf_pkg for register indexes and the cfg_t layout.
`default_nettype none
module erxaf_cfg import erxaf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_STATION:  cfg_nxt.station_address  = cfg_data[ADDR_W-1:0];
        REG_MCAST:    cfg_nxt.multicast_filter = cfg_data[FILTER_W-1:0];
        REG_MODE:     cfg_nxt.filter_mode      = cfg_data[MODE_W-1:0];
        REG_STOPPED:  cfg_nxt.receiver_stopped = cfg_data[0];
        REG_LOOPBACK: cfg_nxt.loopback_on      = cfg_data[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### design/erxaf_crc_stage.sv
// One pipeline stage of the address CRC: folds in the next address byte.
// Depends on erxaf_pkg for stage_t and crc_byte.
`default_nettype none
module erxaf_crc_stage import erxaf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   up_valid,
  input  wire stage_t up_data,
  output logic        up_ready,
  output logic        dn_valid,
  output stage_t      dn_data,
  input  wire logic   dn_ready
);

  logic   valid_r;
  logic   valid_nxt;
  stage_t data_r;
  stage_t data_nxt;

  // Take a new word when empty or when the current one moves on.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    valid_nxt     = up_ready ? up_valid : valid_r;
    data_nxt      = up_data;
    data_nxt.crc  = crc_byte(up_data.crc, up_data.rest[BYTE_W-1:0]);
    data_nxt.rest = up_data.rest >> BYTE_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

### design/erxaf_decide.sv
// Final stage: hash index extraction, filter decision and output register.
// Depends on erxaf_pkg for cfg_t, stage_t and the mode codes.
`default_nettype none
module erxaf_decide import erxaf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        up_valid,
  input  wire stage_t      up_data,
  output logic             up_ready,
  output logic             out_valid,
  output logic             out_accept,
  output logic             out_group_frame,
  output logic [HASH_W-1:0] out_hash_index,
  input  wire logic        out_stall
);

  logic              valid_r;
  logic              valid_nxt;
  logic              accept_r;
  logic              accept_nxt;
  logic              group_r;
  logic              group_nxt;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;

  assign up_ready        = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_accept      = accept_r;
  assign out_group_frame = group_r;
  assign out_hash_index  = hash_r;

  always_comb begin
    // Low CRC bits, bit-reversed.
    for (int k = 0; k < HASH_W; k++) begin
      hash_nxt[HASH_W-1-k] = up_data.crc[k];
    end
    group_nxt = up_data.addr[0];
    valid_nxt = up_ready ? up_valid : valid_r;

    if (!up_data.looped && cfg.loopback_on) begin
      accept_nxt = 1'b0;
    end else if (cfg.filter_mode == MODE_OFF || cfg.receiver_stopped) begin
      accept_nxt = 1'b0;
    end else if (cfg.filter_mode == MODE_PROMISC) begin
      accept_nxt = 1'b1;
    end else if (up_data.addr == ADDR_BCAST) begin
      accept_nxt = 1'b1;
    end else if (group_nxt) begin
      accept_nxt = (cfg.filter_mode >= MODE_MULTICAST) && cfg.multicast_filter[hash_nxt];
    end else begin
      accept_nxt = (up_data.addr == cfg.station_address);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      accept_r <= accept_nxt;
      group_r  <= group_nxt;
      hash_r   <= hash_nxt;
    end
  end

endmodule
`default_nettype wire

### design/ethernet_rx_address_filter_core.sv
// Ethernet receive address filter, top level.
// Depends on erxaf_pkg, erxaf_cfg, erxaf_crc_stage and erxaf_decide.
//
// Input channel (in_valid / in_stall): one word per frame, the 48-bit
// destination address and a loopback flag. Output channel (out_valid /
// out_stall): accept decision, group bit and 6-bit multicast hash index,
// one word per input word, in order.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
// station address, hash filter, mode, stop and loopback registers. It is
// always ready; write it only while no frame is in flight.
//
// An accepted word passes six CRC stages, each folding in one address byte,
// then a decision stage that feeds the output register. Throughput is one
// word per cycle while out_stall is low; the byte-per-stage CRC chain sets
// the depth. Every stage has its own valid bit and fills bubbles, so a
// stalled output only stops the input once all seven stages hold words.
// Synchronous reset empties the pipeline and clears the configuration to 0.
`default_nettype none
module ethernet_rx_address_filter_core import erxaf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ADDR_W-1:0]     in_dest_address,
  input  wire logic                  in_from_loopback,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_accept,
  output logic                       out_group_frame,
  output logic [HASH_W-1:0]          out_hash_index,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   stg_valid [CRC_STAGES+1];
  stage_t stg_data  [CRC_STAGES+1];
  logic   stg_ready [CRC_STAGES+1];

  erxaf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign stg_valid[0] = in_valid;
  assign stg_data[0]  = '{addr:   in_dest_address,
                          rest:   in_dest_address,
                          looped: in_from_loopback,
                          crc:    CRC_INIT};

  assign in_stall = !stg_ready[0];

  for (genvar i = 0; i < CRC_STAGES; i++) begin : g_crc
    erxaf_crc_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_data  (stg_data[i]),
      .up_ready (stg_ready[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_data  (stg_data[i+1]),
      .dn_ready (stg_ready[i+1])
    );
  end

  erxaf_decide u_decide (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .up_valid        (stg_valid[CRC_STAGES]),
    .up_data         (stg_data[CRC_STAGES]),
    .up_ready        (stg_ready[CRC_STAGES]),
    .out_valid       (out_valid),
    .out_accept      (out_accept),
    .out_group_frame (out_group_frame),
    .out_hash_index  (out_hash_index),
    .out_stall       (out_stall)
  );

  // Output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input is held off only when every stage is full and the output is stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && stg_valid[1] && stg_valid[CRC_STAGES]))
    else $error("input stalled with room in the pipeline");

  // An accepted word lands in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> stg_valid[1])
    else $error("accepted word lost at pipeline entry");

endmodule
`default_nettype wire

### bench/ethernet_rx_address_filter_core_tb.sv
// Self-checking bench for ethernet_rx_address_filter_core: directed frames, then random
// frames over many filter settings under three idling regimes. Depends on erxaf_pkg.
`default_nettype none
module ethernet_rx_address_filter_core_tb;
  import erxaf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNICAST = 2'd1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_GAP   = 12;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    bit              accept;
    bit              group;
    bit [HASH_W-1:0] hash;
  } verdict_t;

  // Predicts the filter decision per frame and checks delivered words in order.
  class addr_filter_scoreboard;
    cfg_t     regs;
    verdict_t pending_verdicts[$];
    int       failures;
    int       mismatches;

    function new();
      regs       = '0;
      failures   = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STATION:  regs.station_address  = data[ADDR_W-1:0];
        REG_MCAST:    regs.multicast_filter = data[FILTER_W-1:0];
        REG_MODE:     regs.filter_mode      = data[MODE_W-1:0];
        REG_STOPPED:  regs.receiver_stopped = data[0];
        REG_LOOPBACK: regs.loopback_on      = data[0];
        default: ;
      endcase
    endfunction

    // CRC-32 over the address, LSB first, no final inversion; low six bits reversed.
    function bit [HASH_W-1:0] addr_hash(bit [ADDR_W-1:0] addr);
      bit [CRC_W-1:0]  r;
      bit              fb;
      bit [HASH_W-1:0] h;
      r = CRC_INIT;
      for (int k = 0; k < ADDR_W; k++) begin
        fb = r[CRC_W-1] ^ addr[k];
        r  = {r[CRC_W-2:0], 1'b0};
        if (fb) r = r ^ CRC_POLY;
      end
      for (int k = 0; k < HASH_W; k++) h[HASH_W-1-k] = r[k];
      return h;
    endfunction

    function verdict_t predict_verdict(bit [ADDR_W-1:0] addr, bit looped);
      verdict_t v;
      v.group = addr[0];
      v.hash  = addr_hash(addr);
      if (!looped && regs.loopback_on)
        v.accept = 1'b0;
      else if (regs.filter_mode == MODE_OFF || regs.receiver_stopped)
        v.accept = 1'b0;
      else if (regs.filter_mode == MODE_PROMISC)
        v.accept = 1'b1;
      else if (addr == ADDR_BCAST)
        v.accept = 1'b1;
      else if (v.group)
        v.accept = (regs.filter_mode >= MODE_MULTICAST) && regs.multicast_filter[v.hash];
      else
        v.accept = (addr == regs.station_address);
      return v;
    endfunction

    function void note_frame(bit [ADDR_W-1:0] addr, bit looped);
      pending_verdicts.push_back(predict_verdict(addr, looped));
    endfunction

    function void check_verdict(bit acc, bit grp, bit [HASH_W-1:0] h);
      verdict_t e;
      if (pending_verdicts.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: accept=%0d group=%0d hash=%0d", acc, grp, h);
        return;
      end
      e = pending_verdicts.pop_front();
      if (e.accept !== acc || e.group !== grp || e.hash !== h) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: expected accept=%0d group=%0d hash=%0d, got %0d %0d %0d",
                   e.accept, e.group, e.hash, acc, grp, h);
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADDR_W-1:0]     in_dest_address = '0;
  logic                  in_from_loopback = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_accept;
  logic                  out_group_frame;
  logic [HASH_W-1:0]     out_hash_index;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  addr_filter_scoreboard sb = new();

  ethernet_rx_address_filter_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dest_address  (in_dest_address),
    .in_from_loopback (in_from_loopback),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accept       (out_accept),
    .out_group_frame  (out_group_frame),
    .out_hash_index   (out_hash_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check the delivered word, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_accept, out_group_frame, out_hash_index);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic looped);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_dest_address  <= addr;
    in_from_loopback <= looped;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(addr, looped);
  endtask

  // Hold the input until every expected word is back, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Unused upper data bits carry junk; the block must drop them.
  task automatic reconfigure(input logic [ADDR_W-1:0] station, input logic [FILTER_W-1:0] filt,
                             input logic [MODE_W-1:0] mode, input logic stopped,
                             input logic loopback);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    junk = {$urandom, $urandom};
    cfg_write(REG_STATION, {junk[63:48], station});
    cfg_write(REG_MCAST, filt);
    junk = {$urandom, $urandom};
    cfg_write(REG_MODE, {junk[63:2], mode});
    junk = {$urandom, $urandom};
    cfg_write(REG_STOPPED, {junk[63:1], stopped});
    junk = {$urandom, $urandom};
    cfg_write(REG_LOOPBACK, {junk[63:1], loopback});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setting();
    logic [63:0]         r;
    logic [ADDR_W-1:0]   station;
    logic [FILTER_W-1:0] filt;
    logic [MODE_W-1:0]   mode;
    r       = {$urandom, $urandom};
    station = r[ADDR_W-1:0];
    station[0] = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 3))
      0:       filt = '0;
      1:       filt = '1;
      default: filt = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 9))
      0:       mode = MODE_OFF;
      1, 2, 3: mode = MODE_UNICAST;
      8, 9:    mode = MODE_PROMISC;
      default: mode = MODE_MULTICAST;
    endcase
    reconfigure(station, filt, mode, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic random_frame();
    logic [63:0]       r;
    logic [ADDR_W-1:0] addr;
    r    = {$urandom, $urandom};
    addr = r[ADDR_W-1:0];
    case ($urandom_range(0, 9))
      0, 1, 2: addr = sb.regs.station_address;
      3:       addr = ADDR_BCAST;
      4, 5, 6: addr[0] = 1'b1;
      7:       addr = sb.regs.station_address ^ (48'h1 << $urandom_range(1, ADDR_W - 1));
      default: ;
    endcase
    send_frame(addr, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [ADDR_W-1:0] stn;
    logic [63:0]       r;
    stn = 48'hcafe_0012_3456;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 73;

    // Reset settings: receiver off, everything rejected, fields still valid.
    send_frame('0, 1'b0);
    send_frame(ADDR_BCAST, 1'b1);

    reconfigure(stn, '1, MODE_UNICAST, 1'b0, 1'b0);
    send_frame(stn, 1'b0);
    send_frame(stn ^ 48'h8000_0000_0000, 1'b0);
    send_frame(ADDR_BCAST, 1'b0);
    send_frame(48'h0000_0000_0001, 1'b0);
    send_frame(stn, 1'b1);
    send_frame(48'hffff_ffff_fffe, 1'b0);

    reconfigure(stn, '1, MODE_MULTICAST, 1'b0, 1'b0);
    send_frame(48'h0000_0000_0001, 1'b0);
    send_frame(48'hffff_ffff_fffd, 1'b1);
    send_frame(ADDR_BCAST, 1'b0);

    // Empty hash filter: broadcast still passes without a hash lookup.
    reconfigure(stn, '0, MODE_MULTICAST, 1'b0, 1'b0);
    send_frame(48'h0000_0000_0001, 1'b0);
    send_frame(ADDR_BCAST, 1'b0);
    send_frame(stn, 1'b0);

    // Stop beats promiscuous.
    reconfigure(stn, '1, MODE_PROMISC, 1'b1, 1'b0);
    send_frame(stn, 1'b1);
    send_frame(ADDR_BCAST, 1'b1);

    // Loopback on: network side cut off, looped frames pass.
    reconfigure(stn, '1, MODE_PROMISC, 1'b0, 1'b1);
    send_frame(stn, 1'b0);
    send_frame(stn, 1'b1);
    r = {$urandom, $urandom};
    send_frame(r[ADDR_W-1:0], 1'b1);
    r = {$urandom, $urandom};
    send_frame(r[ADDR_W-1:0], 1'b0);

    reconfigure(ADDR_BCAST, '0, MODE_UNICAST, 1'b0, 1'b0);
    send_frame(ADDR_BCAST, 1'b0);
    send_frame(48'hffff_ffff_fffe, 1'b0);

    reconfigure('0, '0, MODE_UNICAST, 1'b0, 1'b0);
    send_frame('0, 1'b0);

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle_pct = 73;
        recv_idle_pct = 28;
      end
      if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0)
        reconfigure('0, '1, MODE_MULTICAST, 1'b0, 1'b0);
      else
        random_setting();
      for (int i = 0; i < 46; i++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        random_frame();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
design/erxaf_pkg.sv
design/erxaf_cfg.sv
design/erxaf_crc_stage.sv
design/erxaf_decide.sv
design/ethernet_rx_address_filter_core.sv
bench/ethernet_rx_address_filter_core_tb.sv
